// ===== rtl/lrs_pkg.sv =====
// Shared widths, constants and codes for the running Liouville statistics block.
`default_nettype none

package lrs_pkg;

  // Width of the integer that is factored
  localparam int VALUE_BITS = 31;

  // Field widths
  localparam int POS_W      = 31;
  localparam int SUM_W      = 32;
  localparam int FC_W       = 5;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int DIV_CNT_W  = $clog2(VALUE_BITS + 1);

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 32;
  localparam int OUT_FLD_W  = 2 + FC_W + SUM_W + POS_W + POS_W + SUM_W + POS_W + POS_W + POS_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Saturation limits
  localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -32'sh7FFF_FFFF;
  localparam logic [POS_W-1:0]        CNT_MAX = 31'h7FFF_FFFF;

  // Liouville sign codes, also used as the sign of the running sum
  localparam logic signed [1:0] SIGN_POS  = 2'sb01;
  localparam logic signed [1:0] SIGN_NEG  = 2'sb11;
  localparam logic signed [1:0] SIGN_NONE = 2'sb00;

endpackage

`default_nettype wire

// ===== rtl/lrs_divider.sv =====
// Restoring divider, one quotient bit per cycle, quotient and remainder out.
`default_nettype none

module lrs_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lrs_pkg::VALUE_BITS-1:0] dividend,
  input  wire logic [lrs_pkg::VALUE_BITS-1:0] divisor,
  output logic                               done,
  output logic [lrs_pkg::VALUE_BITS-1:0]     quotient,
  output logic [lrs_pkg::VALUE_BITS-1:0]     remainder
);
  import lrs_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  steps;
  logic [VALUE_BITS-1:0] dvs;
  logic [VALUE_BITS:0]   shifted;
  logic                  fits;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {remainder, quotient[VALUE_BITS-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_W'(VALUE_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvs       <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= VALUE_BITS'(shifted - {1'b0, dvs});
      end else begin
        remainder <= shifted[VALUE_BITS-1:0];
      end
      quotient <= {quotient[VALUE_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/liouville_running_statistics.sv =====
// Running Liouville statistics: trial-division factor count and summatory tracking.
//
// Input channel s_*: one integer per transfer (normally 1, 2, 3, ... in order),
// restart flag on s_tuser clears all statistics before that item. s_tready is
// high only while the sequencer is idle; one item is worked on at a time.
// Output channel m_*: one result per input item, held in an output register.
// Sequence: the factors of two are stripped, then each trial division runs
// through the kick, divide and decide states; values 0 and 1 go straight to
// the final state. The shared serial divider does the work: one division per
// odd divisor d up to sqrt(remaining value), one more per odd factor found.
// A prime near 2^31 takes roughly 23000 divisions.
// A finished result waits in the output register while the receiver stalls;
// the next item may be accepted meanwhile, and its result is held back in the
// done state until the output register is free.
// Reset (rst, synchronous) clears the statistics to their start values: sums 0,
// positions 1, counters 0, no previous sign, and drops any pending result.
`default_nettype none

module liouville_running_statistics (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lrs_pkg::IN_DATA_W-1:0] s_tdata,  // [30:0] value, [31] zero
  input  wire logic                          s_tuser,  // [0] restart
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [1:0] lambda_sign, [6:2] factor_count, [38:7] running_sum,
  // [69:39] highest_sum, [100:70] highest_at, [132:101] lowest_sum,
  // [163:133] lowest_at, [194:164] flip count, [225:195] positive_count,
  // [231:226] zero
  output logic [lrs_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import lrs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_KICK,
    ST_DIVIDE,
    ST_DECIDE,
    ST_FINAL,
    ST_DONE
  } state_t;

  state_t state;

  // Factoring registers
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] d;
  logic [CNT_W-1:0]      cnt;
  logic                  first_try;

  // Statistics
  logic signed [SUM_W-1:0] sum_reg;
  logic [POS_W-1:0]        high_reg;
  logic [POS_W-1:0]        high_pos_reg;
  logic signed [SUM_W-1:0] low_reg;
  logic [POS_W-1:0]        low_pos_reg;
  logic [POS_W-1:0]        flip_count_reg;
  logic signed [1:0]       last_sign_reg;
  logic [POS_W-1:0]        positive_reg;

  // Divider hookup
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_q;
  logic [VALUE_BITS-1:0] div_r;

  lrs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (n),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign div_start = (state == ST_KICK);
  assign s_tready  = (state == ST_IDLE);

  logic [VALUE_BITS-1:0] in_value;
  assign in_value = VALUE_BITS'(s_tdata[POS_W-1:0]);

  // Statistics update for the finished item
  logic signed [1:0]       lam;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [1:0]       sum_sign;
  logic                    flip;
  logic                    take_high;
  logic                    take_low;
  logic                    count_pos;
  logic [POS_W-1:0]        pos;
  logic                    out_free;

  always_comb begin
    lam = cnt[0] ? SIGN_NEG : SIGN_POS;
    if (cnt[0]) begin
      sum_next = (sum_reg == SUM_MIN) ? sum_reg : sum_reg - 32'sd1;
    end else begin
      sum_next = (sum_reg == SUM_MAX) ? sum_reg : sum_reg + 32'sd1;
    end
    if (sum_next[SUM_W-1]) begin
      sum_sign = SIGN_NEG;
    end else if (sum_next != '0) begin
      sum_sign = SIGN_POS;
    end else begin
      sum_sign = SIGN_NONE;
    end
    flip      = (last_sign_reg != SIGN_NONE) && (sum_sign != SIGN_NONE) &&
                (sum_sign != last_sign_reg);
    take_high = (sum_sign == SIGN_POS) && (sum_next[POS_W-1:0] > high_reg);
    take_low  = (sum_next < low_reg);
    count_pos = (sum_sign == SIGN_POS) && (v > VALUE_BITS'(1));
    pos       = POS_W'(v);
    out_free  = !m_tvalid || m_tready;
  end

  // Sequencer, statistics and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      sum_reg        <= '0;
      high_reg       <= '0;
      high_pos_reg   <= POS_W'(1);
      low_reg        <= '0;
      low_pos_reg    <= POS_W'(1);
      flip_count_reg <= '0;
      last_sign_reg  <= SIGN_NONE;
      positive_reg   <= '0;
    end else begin
      // the done state reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            v         <= in_value;
            n         <= in_value;
            d         <= VALUE_BITS'(3);
            cnt       <= '0;
            first_try <= 1'b1;
            if (s_tuser) begin
              sum_reg        <= '0;
              high_reg       <= '0;
              high_pos_reg   <= POS_W'(1);
              low_reg        <= '0;
              low_pos_reg    <= POS_W'(1);
              flip_count_reg <= '0;
              last_sign_reg  <= SIGN_NONE;
              positive_reg   <= '0;
            end
            state <= (in_value > VALUE_BITS'(1)) ? ST_STRIP : ST_FINAL;
          end
        end
        // Factors of two, one per cycle
        ST_STRIP: begin
          if (!n[0]) begin
            n   <= n >> 1;
            cnt <= cnt + 1'b1;
          end else begin
            state <= ST_KICK;
          end
        end
        ST_KICK: begin
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_DECIDE;
          end
        end
        // Divisor past the square root ends the search; zero remainder is a factor
        ST_DECIDE: begin
          if (first_try && (d > div_q)) begin
            state <= ST_FINAL;
          end else if (div_r == '0) begin
            cnt       <= cnt + 1'b1;
            n         <= div_q;
            first_try <= 1'b0;
            state     <= ST_KICK;
          end else begin
            d         <= d + VALUE_BITS'(2);
            first_try <= 1'b1;
            state     <= ST_KICK;
          end
        end
        // Leftover prime factor
        ST_FINAL: begin
          if (n > VALUE_BITS'(1)) begin
            cnt <= cnt + 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            sum_reg <= sum_next;
            if (sum_sign != SIGN_NONE) begin
              last_sign_reg <= sum_sign;
            end
            if (flip && (flip_count_reg < CNT_MAX)) begin
              flip_count_reg <= flip_count_reg + 1'b1;
            end
            if (take_high) begin
              high_reg     <= sum_next[POS_W-1:0];
              high_pos_reg <= pos;
            end
            if (take_low) begin
              low_reg     <= sum_next;
              low_pos_reg <= pos;
            end
            if (count_pos && (positive_reg < CNT_MAX)) begin
              positive_reg <= positive_reg + 1'b1;
            end
            m_tdata <= OUT_DATA_W'({
              (count_pos && (positive_reg < CNT_MAX)) ? positive_reg + 1'b1 : positive_reg,
              (flip && (flip_count_reg < CNT_MAX)) ? flip_count_reg + 1'b1 : flip_count_reg,
              take_low ? pos : low_pos_reg,
              take_low ? sum_next : low_reg,
              take_high ? pos : high_pos_reg,
              take_high ? sum_next[POS_W-1:0] : high_reg,
              sum_next,
              FC_W'(cnt),
              lam
            });
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lrs_checker.sv =====
// Port-level checks for the running Liouville statistics block, bound to the top level.
`default_nettype none

module lrs_port_checks (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [231:0] m_tdata
);

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // An accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a transfer");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Sign is always plus or minus one
  a_sign_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[1:0] == 2'b01) || (m_tdata[1:0] == 2'b11)))
    else $error("bad lambda sign code");

  // Running sum never below the tracked minimum
  a_low_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[38:7]) >= $signed(m_tdata[132:101])))
    else $error("running sum below lowest sum");

endmodule

bind liouville_running_statistics lrs_port_checks u_lrs_port_checks (.*);

`default_nettype wire
